// File: rtl/vcfp_pkg.sv
package vcfp_pkg;

  localparam int WinLen   = 11;
  localparam int WinIdxW  = $clog2(WinLen);
  localparam int ByteW    = 8;

  localparam logic [ByteW-1:0] MarkHeadA = 8'hAA;
  localparam logic [ByteW-1:0] MarkHeadB = 8'hA8;
  localparam logic [ByteW-1:0] MarkMid   = 8'h40;
  localparam logic [ByteW-1:0] MarkTailA = 8'hB8;
  localparam logic [ByteW-1:0] MarkTailB = 8'hA9;

  // first slot of each three-copy group, oldest slot is 0
  localparam int ThrSlot = 2;
  localparam int JoySlot = 6;

  typedef struct packed {
    logic             care;
    logic [ByteW-1:0] value;
  } cell_mark_t;

  function automatic cell_mark_t frame_mark(input logic [WinIdxW-1:0] slot);
    cell_mark_t m;
    m.care  = 1'b1;
    m.value = '0;
    case (slot)
      4'd0:  m.value = MarkHeadA;
      4'd1:  m.value = MarkHeadB;
      4'd5:  m.value = MarkMid;
      4'd9:  m.value = MarkTailA;
      4'd10: m.value = MarkTailB;
      default: m.care = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/vcfp_in_if.sv
interface vcfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/vcfp_out_if.sv
interface vcfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] throttle_value;
  logic [7:0] joystick_value;
  logic       frame_matched;

  modport source (output valid, output throttle_value, output joystick_value,
                  output frame_matched, input ready);
  modport sink (input valid, input throttle_value, input joystick_value,
                input frame_matched, output ready);
endinterface

// File: rtl/vcfp_cell.sv
module vcfp_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic [7:0]            byte_i,
  input  vcfp_pkg::cell_mark_t  mark_i,
  output logic [7:0]            byte_o,
  output logic                  hit_o
);
  import vcfp_pkg::*;

  logic [ByteW-1:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // compare on the incoming byte: the slot's content after this shift
  assign hit_o  = !mark_i.care || (byte_i == mark_i.value);

endmodule

// File: rtl/vcfp_vote.sv
module vcfp_vote (
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] c_i,
  input  logic [7:0] keep_i,
  output logic [7:0] vote_o
);
  import vcfp_pkg::*;

  always_comb begin
    if (a_i == b_i) begin
      vote_o = a_i;
    end else if (a_i == c_i) begin
      vote_o = c_i;
    end else if (b_i == c_i) begin
      vote_o = b_i;
    end else begin
      vote_o = keep_i;
    end
  end

endmodule

// File: rtl/voted_command_frame_parser.sv
// channel  | dir | payload                                          | item
// in_i     | in  | rx_byte[7:0]                                     | one received byte
// out_o    | out | throttle_value[7:0] joystick_value[7:0] frame_matched | one status
//
// One item per cycle while out_o is not stalled; each result appears the cycle after its byte is taken.
// The 11-cell byte chain shifts, marker compare and votes all settle in that cycle.
// The output register holds a pending item; in_i.ready = !out_o.valid || out_o.ready.
// rst_ni clears the chain, the held values and the output valid.
module voted_command_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  vcfp_in_if.sink     in_i,
  vcfp_out_if.source  out_o
);
  import vcfp_pkg::*;

  logic [ByteW-1:0] win_q  [WinLen];
  logic [ByteW-1:0] win_in [WinLen];
  logic [WinLen-1:0] hit;
  logic shift;
  logic match;
  logic [ByteW-1:0] thr_vote, joy_vote;
  logic [ByteW-1:0] thr_q, joy_q;
  logic match_q, valid_q;

  assign in_i.ready = !valid_q || out_o.ready;
  assign shift      = in_i.valid && in_i.ready;

  for (genvar k = 0; k < WinLen; k++) begin : g_cell
    if (k == WinLen - 1) begin : g_head
      assign win_in[k] = in_i.rx_byte;
    end else begin : g_body
      assign win_in[k] = win_q[k+1];
    end

    vcfp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .byte_i  (win_in[k]),
      .mark_i  (frame_mark(WinIdxW'(k))),
      .byte_o  (win_q[k]),
      .hit_o   (hit[k])
    );
  end

  assign match = &hit;

  vcfp_vote u_thr_vote (
    .a_i    (win_in[ThrSlot]),
    .b_i    (win_in[ThrSlot+1]),
    .c_i    (win_in[ThrSlot+2]),
    .keep_i (thr_q),
    .vote_o (thr_vote)
  );

  vcfp_vote u_joy_vote (
    .a_i    (win_in[JoySlot]),
    .b_i    (win_in[JoySlot+1]),
    .c_i    (win_in[JoySlot+2]),
    .keep_i (joy_q),
    .vote_o (joy_vote)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      thr_q   <= '0;
      joy_q   <= '0;
    end else begin
      if (shift) begin
        valid_q <= 1'b1;
        match_q <= match;
        if (match) begin
          thr_q <= thr_vote;
          joy_q <= joy_vote;
        end
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.throttle_value = thr_q;
  assign out_o.joystick_value = joy_q;
  assign out_o.frame_matched  = match_q;

endmodule

// File: rtl/vcfp_checker.sv
module vcfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] throttle_i,
  input logic [7:0] joystick_i,
  input logic       matched_i
);
  import vcfp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("out valid dropped while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("accepted item gave no result");

  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  a_keep_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (!matched_i |-> ($stable(throttle_i) && $stable(joystick_i))))
    else $error("held values changed without a frame");

endmodule

bind voted_command_frame_parser vcfp_checker u_vcfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .throttle_i  (out_o.throttle_value),
  .joystick_i  (out_o.joystick_value),
  .matched_i   (out_o.frame_matched)
);
